// ===== rtl/quarter_circle_hit_counter_assert.svh =====
// quarter_circle_hit_counter_assert.svh: assertion macros for the hit counter
// used by qchc_ctrl and qchc_dp; expects clk and rst in scope
`ifndef QUARTER_CIRCLE_HIT_COUNTER_ASSERT_SVH
`define QUARTER_CIRCLE_HIT_COUNTER_ASSERT_SVH

// same-cycle implication
`define QCHC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qchc assertion failed");

// next-cycle implication
`define QCHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qchc assertion failed");

`endif

// ===== rtl/qchc_pkg.sv =====
// qchc_pkg: shared types and constants of the quarter circle hit counter
// no dependencies
package qchc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_SEED_VALUE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRIAL_COUNT = 2'd1;

  localparam logic [WORD_W-1:0] GOLDEN_MIX = 32'h9e3779b9;
  localparam logic [WORD_W-1:0] TRIAL_RESET = 32'h0001_0000;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic trials_zero;
    logic pipe_busy;
  } status_t;

endpackage

// ===== rtl/quarter_circle_hit_counter.sv =====
// Quarter circle hit counter. Each request carries a lane index; the block
// seeds a xorshift32 generator with seed_value XOR (0x9e3779b9 * lane_index),
// draws trial_count point pairs (x, y) and returns how many satisfy
// x^2 + y^2 <= 2^64, read as fractions of 2^32. One request is in flight at a
// time: the result turns valid once the trial pipeline, which draws one point
// per cycle (generator, squaring stage, compare and tally), has drained and
// the output register is free, and a new request is taken only after the
// previous result has been published. The result sits in an output register,
// so the next request is accepted while it waits. Configuration writes are
// taken at any time and must only be issued while no request is in flight.
// Depends on qchc_pkg, qchc_ctrl and qchc_dp.
module quarter_circle_hit_counter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [qchc_pkg::WORD_W-1:0]        lane_index,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [qchc_pkg::WORD_W-1:0]        inside_count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qchc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [qchc_pkg::WORD_W-1:0]        cfg_data
);

  qchc_pkg::cmd_t    cmd;
  qchc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  qchc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd),
    .status    (status)
  );

  qchc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .lane_index   (lane_index),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .inside_count (inside_count)
  );

endmodule

// ===== rtl/qchc_dp.sv =====
// qchc_dp: datapath with config registers, xorshift32 generator, trial pipeline
// and hit tally; depends on qchc_pkg and the assertion macro header
`include "quarter_circle_hit_counter_assert.svh"

module qchc_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  qchc_pkg::cmd_t                     cmd,
  output qchc_pkg::status_t                  status,
  input  logic [qchc_pkg::WORD_W-1:0]        lane_index,
  input  logic                               cfg_valid,
  input  logic [qchc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [qchc_pkg::WORD_W-1:0]        cfg_data,
  output logic [qchc_pkg::WORD_W-1:0]        inside_count
);

  function automatic logic [qchc_pkg::WORD_W-1:0] xs_advance(
    input logic [qchc_pkg::WORD_W-1:0] w
  );
    logic [qchc_pkg::WORD_W-1:0] t;
    t = w ^ (w << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  logic [qchc_pkg::WORD_W-1:0]   seed_value;
  logic [qchc_pkg::WORD_W-1:0]   trial_count;
  logic [qchc_pkg::WORD_W-1:0]   rng_word;
  logic [qchc_pkg::WORD_W-1:0]   trials_left;
  logic [qchc_pkg::WORD_W-1:0]   hit_tally;
  logic [qchc_pkg::WORD_W-1:0]   x_word;
  logic [qchc_pkg::WORD_W-1:0]   y_word;
  logic [2*qchc_pkg::WORD_W-1:0] xx_sq;
  logic [2*qchc_pkg::WORD_W-1:0] yy_sq;
  logic                          sq_in_valid;
  logic                          sum_in_valid;

  logic [qchc_pkg::WORD_W-1:0]   lane_mix;
  logic [qchc_pkg::WORD_W-1:0]   x_next;
  logic [qchc_pkg::WORD_W-1:0]   y_next;
  logic [2*qchc_pkg::WORD_W:0]   sq_sum;
  logic                          hit;

  assign lane_mix = lane_index * qchc_pkg::GOLDEN_MIX;
  assign x_next   = xs_advance(rng_word);
  assign y_next   = xs_advance(x_next);
  assign sq_sum   = {1'b0, xx_sq} + {1'b0, yy_sq};
  // inside when x^2 + y^2 <= 2^64
  assign hit      = !sq_sum[2*qchc_pkg::WORD_W] || (sq_sum[2*qchc_pkg::WORD_W-1:0] == '0);

  assign status.trials_zero = (trials_left == '0);
  assign status.pipe_busy   = sq_in_valid || sum_in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value   <= '0;
      trial_count  <= qchc_pkg::TRIAL_RESET;
      trials_left  <= '0;
      sq_in_valid  <= 1'b0;
      sum_in_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          qchc_pkg::REG_SEED_VALUE:  seed_value  <= cfg_data;
          qchc_pkg::REG_TRIAL_COUNT: trial_count <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        trials_left <= trial_count;
      end else if (cmd.step) begin
        trials_left <= trials_left - 32'd1;
      end
      sq_in_valid  <= cmd.step;
      sum_in_valid <= sq_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rng_word <= '0;
    end else if (cmd.load) begin
      rng_word <= seed_value ^ lane_mix;
    end else if (cmd.step) begin
      rng_word <= y_next;
    end
    x_word <= x_next;
    y_word <= y_next;
    xx_sq  <= x_word * x_word;
    yy_sq  <= y_word * y_word;
    if (rst) begin
      hit_tally <= '0;
    end else if (cmd.load) begin
      hit_tally <= '0;
    end else if (sum_in_valid && hit) begin
      hit_tally <= hit_tally + 32'd1;
    end
    if (cmd.publish) begin
      inside_count <= hit_tally;
    end
  end

  `QCHC_ASSERT_NEXT(a_pipe_advance, sq_in_valid, sum_in_valid)
  `QCHC_ASSERT_NEXT(a_trial_decrement, cmd.step && !cmd.load,
                    trials_left == $past(trials_left) - 32'd1)
  `QCHC_ASSERT_NEXT(a_load_clears_tally, cmd.load, hit_tally == '0)

endmodule

// ===== rtl/qchc_ctrl.sv =====
// qchc_ctrl: request sequencer and result register control
// depends on qchc_pkg and the assertion macro header
`include "quarter_circle_hit_counter_assert.svh"

module qchc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              res_valid,
  input  logic              res_stall,
  output qchc_pkg::cmd_t    cmd,
  input  qchc_pkg::status_t status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free   = !res_valid || !res_stall;
  assign req_stall   = (state != S_IDLE);
  assign cmd.load    = (state == S_IDLE) && req_valid;
  assign cmd.step    = (state == S_RUN) && !status.trials_zero;
  assign cmd.publish = (state == S_DONE) && slot_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req_valid) state_next = S_RUN;
      S_RUN:   if (status.trials_zero) state_next = S_DRAIN;
      S_DRAIN: if (!status.pipe_busy) state_next = S_DONE;
      S_DONE:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  `QCHC_ASSERT_NOW(a_no_overwrite, cmd.publish, !(res_valid && res_stall))
  `QCHC_ASSERT_NEXT(a_accept_runs, req_valid && !req_stall, state == S_RUN)
  `QCHC_ASSERT_NOW(a_idle_pipe_empty, state == S_IDLE, !status.pipe_busy)

endmodule

// ===== tb/tb_quarter_circle_hit_counter.sv =====
// tb_quarter_circle_hit_counter: self-checking testbench for the quarter circle hit counter
// drives lane requests and register writes, predicts hit counts with an xorshift32 model
// depends on qchc_pkg and quarter_circle_hit_counter
module tb_quarter_circle_hit_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import qchc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int unsigned RANDOM_REQUESTS = 100;

  class hit_board;
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] trials;
    logic [WORD_W-1:0] expected_counts[$];
    int unsigned failures;

    function new();
      seed = '0;
      trials = TRIAL_RESET;
      failures = 0;
    endfunction

    function void mirror_reg(logic [CFG_INDEX_W-1:0] idx, logic [WORD_W-1:0] value);
      case (idx)
        REG_SEED_VALUE: seed = value;
        REG_TRIAL_COUNT: trials = value;
        default: ;
      endcase
    endfunction

    function logic [WORD_W-1:0] xorshift(logic [WORD_W-1:0] w);
      w = w ^ (w << 13);
      w = w ^ (w >> 17);
      w = w ^ (w << 5);
      return w;
    endfunction

    function logic [WORD_W-1:0] count_inside(logic [WORD_W-1:0] lane);
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] left;
      logic [WORD_W-1:0] hits;
      logic [63:0] xx;
      logic [63:0] yy;
      logic [64:0] total;
      word = seed ^ (GOLDEN_MIX * lane);
      hits = '0;
      left = trials;
      while (left != 0) begin
        word = xorshift(word);
        x = word;
        word = xorshift(word);
        y = word;
        xx = 64'(x) * 64'(x);
        yy = 64'(y) * 64'(y);
        total = 65'(xx) + 65'(yy);
        if (total <= {1'b1, 64'h0}) begin
          hits = hits + 1;
        end
        left = left - 1;
      end
      return hits;
    endfunction

    function void note_request(logic [WORD_W-1:0] lane);
      expected_counts.push_back(count_inside(lane));
    endfunction

    function void check_result(logic [WORD_W-1:0] actual);
      logic [WORD_W-1:0] want;
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected inside_count %0d, expected none", $time, actual);
        failures++;
      end else begin
        want = expected_counts.pop_front();
        if (actual !== want) begin
          $display("%0t: inside_count expected %0d, actual %0d", $time, want, actual);
          failures++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_counts.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  logic [WORD_W-1:0] lane_index;
  logic res_valid;
  logic res_stall;
  logic [WORD_W-1:0] inside_count;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;

  hit_board board;
  bit no_idle;

  quarter_circle_hit_counter dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .lane_index(lane_index),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .inside_count(inside_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(negedge clk) begin
    res_stall <= !no_idle && ($urandom_range(0, 99) < 30);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      board.check_result(inside_count);
    end
  end

  task automatic send_lane(input logic [WORD_W-1:0] lane);
    while (!no_idle && $urandom_range(0, 99) < 30) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    lane_index <= lane;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(lane);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.mirror_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // lowers the request line and waits for every outstanding count
  task automatic wait_drained();
    req_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (board.pending() != 0);
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase_no;
    int unsigned burst;
    int unsigned pick;
    logic [WORD_W-1:0] zero_lane;
    logic [WORD_W-1:0] lane;
    bit has_zero_lane;
    board = new();
    rst = 1'b1;
    req_valid = 1'b0;
    lane_index = '0;
    res_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_idle = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: seed 0 and trial count 0x10000, lane 0 gives an all-zero generator
    send_lane(32'h0000_0000);
    send_lane(32'hffff_ffff);
    wait_drained();

    // largest trial count is only stored, then replaced before any request
    cfg_write(REG_TRIAL_COUNT, 32'hffff_ffff);
    cfg_write(REG_SEED_VALUE, 32'hffff_ffff);
    cfg_write(REG_TRIAL_COUNT, 32'h0000_0000);
    cfg_write(REG_SPARE_2, 32'hffff_ffff);
    cfg_write(REG_SPARE_3, 32'h5a5a_a5a5);
    send_lane(32'h0000_0000);
    send_lane(32'h0000_0001);
    send_lane(32'hffff_ffff);
    send_lane(32'h8000_0000);
    wait_drained();

    // single trial, lane 1 cancels the seed to a zero generator word
    cfg_write(REG_SEED_VALUE, GOLDEN_MIX);
    cfg_write(REG_TRIAL_COUNT, 32'h0000_0001);
    send_lane(32'h0000_0001);
    send_lane(32'h0000_0000);
    send_lane(32'hffff_ffff);
    send_lane(32'h5555_5555);
    send_lane(32'haaaa_aaaa);
    wait_drained();

    cfg_write(REG_SEED_VALUE, 32'h0000_0000);
    cfg_write(REG_TRIAL_COUNT, 32'd37);
    send_lane(32'h0000_0000);
    send_lane(32'h0000_0001);
    send_lane(32'hffff_ffff);
    send_lane(32'h1234_5678);
    send_lane(32'h8000_0000);
    wait_drained();

    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_REQUESTS) begin
      wait_drained();
      no_idle = (phase_no == 3);
      pick = $urandom_range(0, 9);
      has_zero_lane = 1'b0;
      zero_lane = $urandom;
      case (pick)
        0: cfg_write(REG_SEED_VALUE, 32'h0000_0000);
        1: cfg_write(REG_SEED_VALUE, 32'hffff_ffff);
        2: begin
          cfg_write(REG_SEED_VALUE, GOLDEN_MIX * zero_lane);
          has_zero_lane = 1'b1;
        end
        default: cfg_write(REG_SEED_VALUE, $urandom);
      endcase
      if ($urandom_range(0, 9) == 0) begin
        cfg_write(REG_TRIAL_COUNT, $urandom_range(1000, 2000));
      end else begin
        cfg_write(REG_TRIAL_COUNT, $urandom_range(0, 300));
      end
      if ($urandom_range(0, 3) == 0) begin
        cfg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
      end
      burst = $urandom_range(4, 12);
      repeat (burst) begin
        lane = (has_zero_lane && $urandom_range(0, 3) == 0) ? zero_lane : $urandom;
        send_lane(lane);
        sent++;
        if (sent == 60) begin
          wait_drained();
        end
      end
      phase_no++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (board.pending() != 0) begin
      $display("%0t: %0d inside_count results never arrived", $time, board.pending());
      board.failures++;
    end
    if (board.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/qchc_pkg.sv
rtl/qchc_dp.sv
rtl/qchc_ctrl.sv
rtl/quarter_circle_hit_counter.sv
tb/tb_quarter_circle_hit_counter.sv
